// ===== sv/poi_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_pkg
// Shared constants, types and the arctangent table of the odometry integrator.
// ----------------------------------------------------------------------------
package poi_pkg;

  localparam int unsigned CordicStepsDefault = 16;
  localparam int unsigned PosBitsDefault     = 32;

  // CORDIC start vector, inverse of the infinite-iteration gain in Q2.30
  localparam logic signed [33:0] CordicGainQ30 = 34'sd652032875;
  // one million, the divisor for the distance
  localparam logic [19:0] OneE6 = 20'd1000000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIST,
    ST_ROT,
    ST_MUL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic start;
    logic busy;
  } ctrl_t;

  // arctangent table in 2^-32 turn
  function automatic logic [31:0] atan_lut(input logic [4:0] idx);
    logic [31:0] r;
    begin
      unique case (idx)
        5'd0:  r = 32'd536870912;
        5'd1:  r = 32'd316933406;
        5'd2:  r = 32'd167458907;
        5'd3:  r = 32'd85004756;
        5'd4:  r = 32'd42667331;
        5'd5:  r = 32'd21354465;
        5'd6:  r = 32'd10679838;
        5'd7:  r = 32'd5340245;
        5'd8:  r = 32'd2670163;
        5'd9:  r = 32'd1335087;
        5'd10: r = 32'd667544;
        5'd11: r = 32'd333772;
        5'd12: r = 32'd166886;
        5'd13: r = 32'd83443;
        5'd14: r = 32'd41722;
        5'd15: r = 32'd20861;
        5'd16: r = 32'd10430;
        5'd17: r = 32'd5215;
        5'd18: r = 32'd2608;
        5'd19: r = 32'd1304;
        5'd20: r = 32'd652;
        5'd21: r = 32'd326;
        5'd22: r = 32'd163;
        5'd23: r = 32'd81;
        5'd24: r = 32'd41;
        5'd25: r = 32'd20;
        5'd26: r = 32'd10;
        5'd27: r = 32'd5;
        5'd28: r = 32'd3;
        5'd29: r = 32'd1;
        5'd30: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

// ===== sv/poi_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_in_if / poi_out_if
// Valid/ready channels carrying odometry items and pose results.
// ----------------------------------------------------------------------------
interface poi_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] lin_vel;
  logic signed [15:0] ang_vel;
  logic        [15:0] dt_us;
  modport source (output valid, lin_vel, ang_vel, dt_us, input ready);
  modport sink   (input valid, lin_vel, ang_vel, dt_us, output ready);
endinterface

interface poi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [31:0] heading;
  logic signed [15:0] quat_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] echo_lin_vel;
  logic signed [15:0] echo_ang_vel;
  modport source (output valid, pos_x, pos_y, heading, quat_z, quat_w,
                  echo_lin_vel, echo_ang_vel, input ready);
  modport sink   (input valid, pos_x, pos_y, heading, quat_z, quat_w,
                  echo_lin_vel, echo_ang_vel, output ready);
endinterface

// ===== sv/planar_odometry_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_odometry_integrator
// Dead-reckoning pose integrator with heading, saturating position and yaw
// quaternion.
// ----------------------------------------------------------------------------
// One item at a time. From one input transfer to the next an item passes
// through the distance divider (prescale, 40 restoring steps by one million,
// hand-off), the heading CORDIC, the position products, the half-heading
// CORDIC, the load of the output register and the idle state in which the
// next item is taken. Both CORDIC passes share a single unit. The result
// waits in an output register; while that register is full and not being
// drained the finished item waits and no new item is taken.
module planar_odometry_integrator #(
  parameter int unsigned CordicSteps = poi_pkg::CordicStepsDefault,
  parameter int unsigned PosBits     = poi_pkg::PosBitsDefault
) (
  input logic clk_i,
  input logic rst_ni,
  poi_in_if.sink    in_i,
  poi_out_if.source out_o
);

  localparam logic signed [PosBits-1:0] PosMax = {1'b0, {(PosBits-1){1'b1}}};
  localparam logic signed [PosBits-1:0] PosMin = {1'b1, {(PosBits-1){1'b0}}};

  poi_pkg::state_e state_q, state_d;

  logic signed [PosBits-1:0] x_acc_q, y_acc_q;
  logic        [31:0]        yaw_q;
  logic signed [15:0]        lin_q, ang_q;
  logic                      neg_q;
  logic        [39:0]        num_q;   // magnitude shift register / quotient
  logic        [20:0]        rem_q;
  logic        [5:0]         cnt_q;
  logic                      half_q;  // second CORDIC pass
  logic signed [33:0]        c_q, s_q;
  logic signed [33:0]        d_q;
  logic signed [67:0]        px_q, py_q;
  logic        [1:0]         mstep_q;

  logic                      out_valid_q;
  logic signed [31:0]        ox_q, oy_q;
  logic        [31:0]        oh_q;
  logic signed [15:0]        oz_q, ow_q, oel_q, oea_q;

  poi_pkg::ctrl_t            cctl;
  logic                      cdone;
  logic signed [33:0]        ccos, csin;
  logic        [31:0]        cang;

  logic                      accept, take_out, slot_free;
  logic signed [31:0]        prod_in;
  logic        [20:0]        rem_sh;
  logic        [20:0]        rem_sub;
  logic signed [52:0]        mul_p;

  assign slot_free = !out_valid_q || out_o.ready;
  assign take_out  = out_valid_q && out_o.ready;
  assign accept    = in_i.valid && in_i.ready;
  assign prod_in   = 32'(in_i.lin_vel * $signed({1'b0, in_i.dt_us}));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      poi_pkg::ST_IDLE: if (accept) state_d = poi_pkg::ST_DIST;
      poi_pkg::ST_DIST: if (cnt_q == 6'd41) state_d = poi_pkg::ST_ROT;
      poi_pkg::ST_ROT:  if (cdone) state_d = half_q ? poi_pkg::ST_DONE : poi_pkg::ST_MUL;
      poi_pkg::ST_MUL:  if (mstep_q == 2'd2) state_d = poi_pkg::ST_ROT;
      poi_pkg::ST_DONE: if (slot_free) state_d = poi_pkg::ST_IDLE;
      default:          state_d = poi_pkg::ST_IDLE;
    endcase
  end

  // handshake and CORDIC control
  always_comb begin
    in_i.ready = (state_q == poi_pkg::ST_IDLE);
    cctl.start = ((state_q == poi_pkg::ST_DIST) && (cnt_q == 6'd41)) ||
                 ((state_q == poi_pkg::ST_MUL) && (mstep_q == 2'd2));
    cctl.busy  = (state_q == poi_pkg::ST_ROT);
  end

  assign cang = half_q || (state_q == poi_pkg::ST_MUL) ? {1'b0, yaw_q[31:1]} : yaw_q;

  poi_cordic #(.CordicSteps(CordicSteps)) u_cordic (
    .clk_i, .rst_ni, .ctrl_i(cctl), .angle_i(cang),
    .done_o(cdone), .cos_o(ccos), .sin_o(csin)
  );

  // restoring division step of |p|*256 (p = lin*dt, 40 bits) by one million
  assign rem_sh  = {rem_q[19:0], num_q[39]};
  assign rem_sub = rem_sh - {1'b0, poi_pkg::OneE6};

  // shared position multiplier, distance fits 21 bits and cos/sin 32 bits
  assign mul_p = $signed(d_q[20:0]) *
                 (mstep_q == 2'd0 ? $signed(c_q[31:0]) : $signed(s_q[31:0]));

  function automatic logic signed [15:0] to_q14(input logic signed [33:0] v);
    logic signed [33:0] r;
    begin
      r = (v + 34'sd32768) >>> 16;
      if (r > 34'sd16384) r = 34'sd16384;
      else if (r < -34'sd16384) r = -34'sd16384;
      return r[15:0];
    end
  endfunction

  function automatic logic signed [PosBits-1:0] sat_add(
      input logic signed [PosBits-1:0] a, input logic signed [67:0] p);
    logic signed [68:0] t;
    logic signed [68:0] sm;
    begin
      t  = (69'(p) + 69'sd536870912) >>> 30;
      sm = 69'(a) + t;
      if (sm > 69'(PosMax)) return PosMax;
      if (sm < 69'(PosMin)) return PosMin;
      return sm[PosBits-1:0];
    end
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PosBits-1:0] v);
    logic signed [48:0] w;
    begin
      w = 49'(v);
      if (w > 49'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (w < -49'sh8000_0000) return 32'sh8000_0000;
      return w[31:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= poi_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      yaw_q       <= '0;
    end else begin
      state_q <= state_d;
      // result register fills from the done state, empties on transfer
      if (state_q == poi_pkg::ST_DONE && slot_free) out_valid_q <= 1'b1;
      else if (take_out) out_valid_q <= 1'b0;
      // heading update on transfer
      if (accept) yaw_q <= yaw_q + ((32'(in_i.ang_vel) * 32'(in_i.dt_us)) << 4);
      // position update, both products added to the accumulators with saturation
      if (state_q == poi_pkg::ST_MUL && mstep_q == 2'd2) begin
        x_acc_q <= sat_add(x_acc_q, px_q);
        y_acc_q <= sat_add(y_acc_q, py_q);
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      poi_pkg::ST_IDLE: begin
        if (accept) begin
          lin_q  <= in_i.lin_vel;
          ang_q  <= in_i.ang_vel;
          neg_q  <= prod_in[31];
          num_q  <= {8'h00, (prod_in[31] ? -prod_in : prod_in)};
          rem_q  <= '0;
          cnt_q  <= '0;
          half_q <= 1'b0;
        end
      end
      poi_pkg::ST_DIST: begin
        if (cnt_q == 6'd0) begin
          // prescale by 256 and add half the divisor for rounding
          num_q <= {num_q[31:0], 8'h00} + 40'd500000;
          cnt_q <= cnt_q + 1'b1;
        end else if (cnt_q != 6'd41) begin
          if (!rem_sub[20]) begin
            rem_q <= rem_sub;
            num_q <= {num_q[38:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            num_q <= {num_q[38:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
        end else begin
          d_q <= neg_q ? -34'(num_q) : 34'(num_q);
        end
      end
      poi_pkg::ST_ROT: begin
        if (cdone) begin
          c_q <= ccos;
          s_q <= csin;
          mstep_q <= '0;
        end
      end
      poi_pkg::ST_MUL: begin
        if (mstep_q == 2'd0) px_q <= 68'(mul_p);
        if (mstep_q == 2'd1) py_q <= 68'(mul_p);
        if (mstep_q == 2'd2) half_q <= 1'b1;
        mstep_q <= mstep_q + 1'b1;
      end
      poi_pkg::ST_DONE: begin
        if (slot_free) begin
          ox_q  <= sat32(x_acc_q);
          oy_q  <= sat32(y_acc_q);
          oh_q  <= yaw_q;
          oz_q  <= to_q14(s_q);
          ow_q  <= to_q14(c_q);
          oel_q <= lin_q;
          oea_q <= ang_q;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.pos_x        = ox_q;
  assign out_o.pos_y        = oy_q;
  assign out_o.heading      = oh_q;
  assign out_o.quat_z       = oz_q;
  assign out_o.quat_w       = ow_q;
  assign out_o.echo_lin_vel = oel_q;
  assign out_o.echo_ang_vel = oea_q;

endmodule

// ===== sv/poi_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle, giving cosine
// and sine in Q2.30 of a 32-bit binary angle.
// ----------------------------------------------------------------------------
module poi_cordic #(
  parameter int unsigned CordicSteps = poi_pkg::CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  poi_pkg::ctrl_t     ctrl_i,
  input  logic        [31:0] angle_i,
  output logic               done_o,
  output logic signed [33:0] cos_o,
  output logic signed [33:0] sin_o
);

  localparam int unsigned IterW = 5;
  localparam logic [IterW-1:0] LastIter = IterW'(CordicSteps - 1);

  logic              run_q, run_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic              flip_q, flip_d;
  logic signed [33:0] x_q, x_d, y_q, y_d;
  logic signed [33:0] z_q, z_d;
  logic signed [33:0] xs, ys, atn;
  logic              flip_in;

  assign flip_in = (angle_i + 32'h4000_0000) >= 32'h8000_0000;
  assign xs  = x_q >>> iter_q;
  assign ys  = y_q >>> iter_q;
  assign atn = {2'b00, poi_pkg::atan_lut(iter_q)};

  // iteration step
  always_comb begin
    run_d  = run_q;
    iter_d = iter_q;
    flip_d = flip_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    done_o = 1'b0;
    if (ctrl_i.start) begin
      run_d  = 1'b1;
      iter_d = '0;
      flip_d = flip_in;
      x_d    = poi_pkg::CordicGainQ30;
      y_d    = '0;
      z_d    = 34'(signed'(flip_in ? (angle_i ^ 32'h8000_0000) : angle_i));
    end else if (run_q) begin
      if (!z_q[33]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atn;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atn;
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == LastIter) begin
        run_d  = 1'b0;
        done_o = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
    end else begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // undo the half-turn pre-rotation on the final vector
  assign cos_o = flip_q ? -x_d : x_d;
  assign sin_o = flip_q ? -y_d : y_d;

endmodule

// ===== sv/poi_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poi_checker
// Port-level checks of the odometry integrator, bound to the top level.
// ----------------------------------------------------------------------------
module poi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] heading,
  input logic [15:0] quat_w
);

  // a pending result holds until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(heading))
    else $error("result dropped");

  // no new transfer in while one item is at work
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken");

  // quaternion w stays within the unit range of Q1.14
  a_qw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> ($signed(quat_w) >= -16'sd16384) && ($signed(quat_w) <= 16'sd16384))
    else $error("quat_w out of range");

endmodule

bind planar_odometry_integrator poi_checker u_poi_checker (
  .clk_i, .rst_ni,
  .in_valid(in_i.valid), .in_ready(in_i.ready),
  .out_valid(out_o.valid), .out_ready(out_o.ready),
  .heading(out_o.heading), .quat_w(out_o.quat_w)
);
